>>> rtl/gamma2_alpha_blend_pixel_core_defines.svh
`ifndef GAMMA2_ALPHA_BLEND_PIXEL_CORE_DEFINES_SVH
`define GAMMA2_ALPHA_BLEND_PIXEL_CORE_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define GABP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Pixel blend check failed.");

// Antecedent implies consequent a fixed number of cycles later.
`define GABP_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("Pixel blend timing check failed.");

`endif

>>> rtl/gabp_pkg.sv
`default_nettype none

package gabp_pkg;

    localparam int LIN_W       = 17;
    localparam int SUM_W       = 18;
    localparam int RHS_W       = 20;
    localparam int NUM_COLOURS = 3;
    localparam int PRE_STAGES  = 4;
    localparam int SQRT_STEPS  = 8;
    localparam int LATENCY     = PRE_STAGES + SQRT_STEPS;

    localparam logic [LIN_W-1:0] LIN_ONE     = 17'd65536;
    localparam logic [8:0]       OPACITY_ONE = 9'd256;
    localparam logic [17:0]      SQRT_SCALE  = 18'd260100;
    localparam logic [9:0]       ALPHA_SCALE = 10'd510;

    typedef logic [LIN_W-1:0] lin_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [RHS_W-1:0] rhs_t;
    typedef lin_t lin_table_t [256];

    // Colour code c maps to c*c*65536/65025, rounded half up.
    function automatic lin_table_t build_colour_table();
        lin_table_t  tab;
        logic [63:0] num;
        for (int c = 0; c < 256; c++)
        begin
            num    = 64'(c) * 64'(c) * 64'd131072 + 64'd65025;
            tab[c] = LIN_W'(num / 64'd130050);
        end
        return tab;
    endfunction

    // Alpha code a maps to a*65536/255, rounded half up.
    function automatic lin_table_t build_alpha_table();
        lin_table_t  tab;
        logic [63:0] num;
        for (int a = 0; a < 256; a++)
        begin
            num    = 64'(a) * 64'd131072 + 64'd255;
            tab[a] = LIN_W'(num / 64'd510);
        end
        return tab;
    endfunction

    localparam lin_table_t COLOUR_LIN = build_colour_table();
    localparam lin_table_t ALPHA_LIN  = build_alpha_table();

endpackage

`default_nettype wire

>>> rtl/gamma2_alpha_blend_pixel_core.sv
// Gamma-2 premultiplied over blend of one ARGB8888 source pixel onto one
// destination pixel. The core takes an item at every clock edge where start
// is high; busy never rises, so one pixel per cycle is sustained. Each item
// yields its blended pixel on blended_pixel with blended_valid high for one
// cycle, after the item has gone through the pipeline: four stages for
// linearization, opacity scaling, blending and the square-root operand, then
// eight stages of the bit-per-stage square root. The receiver cannot stall
// the core, so results must be taken as they appear. The opacity register
// is written through cfg_valid and blend_opacity; the user must write it
// only while no items are in flight (unenforced); values over 256 act as 256.
`default_nettype none

`include "gamma2_alpha_blend_pixel_core_defines.svh"

module gamma2_alpha_blend_pixel_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [31:0] source_pixel,
    input  wire logic [31:0] target_pixel,
    output logic             blended_valid,
    output logic [31:0]      blended_pixel,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  blend_opacity
);

    localparam int NC    = gabp_pkg::NUM_COLOURS;
    localparam int STEPS = gabp_pkg::SQRT_STEPS;

    logic       accept;
    logic [8:0] opacity_reg;
    logic [8:0] op;

    logic [gabp_pkg::PRE_STAGES-2:0] stage_valid_reg;

    gabp_pkg::lin_t src_lin_reg [NC+1];
    gabp_pkg::lin_t src_lin_next [NC+1];
    gabp_pkg::lin_t dst_lin_reg [NC+1];
    gabp_pkg::lin_t dst_lin_next [NC+1];

    gabp_pkg::lin_t src_scl_reg [NC+1];
    gabp_pkg::lin_t src_scl_next [NC+1];
    gabp_pkg::lin_t dst_dly_reg [NC+1];

    logic [24:0]    scl_prod [NC+1];
    gabp_pkg::lin_t inv_alpha;
    logic [32:0]    keep [NC+1];
    gabp_pkg::sum_t sum_reg [NC+1];
    gabp_pkg::sum_t sum_next [NC+1];

    logic [35:0]    rhs_prod [NC];
    logic [26:0]    alpha_prod;
    logic [9:0]     alpha_wide;
    logic [7:0]     alpha_next;

    gabp_pkg::rhs_t rhs_reg [STEPS+1][NC];
    gabp_pkg::rhs_t rhs_next [STEPS+1][NC];
    logic [7:0]     root_reg [STEPS+1][NC];
    logic [7:0]     root_next [STEPS+1][NC];
    logic [7:0]     alpha_reg [STEPS+1];
    logic [STEPS:0] sq_valid_reg;

    logic [7:0]     trial [STEPS][NC];
    logic [8:0]     odd [STEPS][NC];
    logic [17:0]    odd_sq [STEPS][NC];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign op        = (opacity_reg > gabp_pkg::OPACITY_ONE) ? gabp_pkg::OPACITY_ONE
                                                             : opacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= gabp_pkg::OPACITY_ONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            opacity_reg <= blend_opacity;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            sq_valid_reg    <= '0;
        end
        else
        begin
            stage_valid_reg <= {stage_valid_reg[gabp_pkg::PRE_STAGES-3:0], accept};
            sq_valid_reg    <= {sq_valid_reg[STEPS-1:0],
                                stage_valid_reg[gabp_pkg::PRE_STAGES-2]};
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < NC; ch++)
        begin
            src_lin_next[ch] = gabp_pkg::COLOUR_LIN[source_pixel[8*ch +: 8]];
            dst_lin_next[ch] = gabp_pkg::COLOUR_LIN[target_pixel[8*ch +: 8]];
        end
        src_lin_next[NC] = gabp_pkg::ALPHA_LIN[source_pixel[31:24]];
        dst_lin_next[NC] = gabp_pkg::ALPHA_LIN[target_pixel[31:24]];

        for (int ch = 0; ch <= NC; ch++)
        begin
            scl_prod[ch]     = 25'(src_lin_reg[ch]) * 25'(op) + 25'd128;
            src_scl_next[ch] = gabp_pkg::LIN_W'(scl_prod[ch] >> 8);
        end

        inv_alpha = gabp_pkg::LIN_ONE - src_scl_reg[NC];
        for (int ch = 0; ch <= NC; ch++)
        begin
            keep[ch]     = 33'(dst_dly_reg[ch]) * 33'(inv_alpha) + 33'd32768;
            sum_next[ch] = gabp_pkg::SUM_W'(keep[ch][32:16])
                         + gabp_pkg::SUM_W'(src_scl_reg[ch]);
        end

        for (int ch = 0; ch < NC; ch++)
        begin
            rhs_prod[ch]       = 36'(sum_reg[ch]) * 36'(gabp_pkg::SQRT_SCALE);
            rhs_next[0][ch]    = rhs_prod[ch][35:16];
            root_next[0][ch]   = '0;
        end
        alpha_prod = 27'(sum_reg[NC]) * 27'(gabp_pkg::ALPHA_SCALE) + 27'd65536;
        alpha_wide = alpha_prod[26:17];
        alpha_next = (|alpha_wide[9:8]) ? 8'hff : alpha_wide[7:0];

        // Each stage tries one result bit, most significant first: the bit stays
        // when (2n-1)^2 does not exceed the scaled operand.
        for (int s = 0; s < STEPS; s++)
        begin
            for (int ch = 0; ch < NC; ch++)
            begin
                trial[s][ch]       = root_reg[s][ch] | (8'd1 << (STEPS - 1 - s));
                odd[s][ch]         = {trial[s][ch], 1'b0} - 9'd1;
                odd_sq[s][ch]      = 18'(odd[s][ch]) * 18'(odd[s][ch]);
                rhs_next[s+1][ch]  = rhs_reg[s][ch];
                root_next[s+1][ch] = (gabp_pkg::RHS_W'(odd_sq[s][ch]) <= rhs_reg[s][ch])
                                   ? trial[s][ch] : root_reg[s][ch];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_lin_reg <= src_lin_next;
        dst_lin_reg <= dst_lin_next;
        src_scl_reg <= src_scl_next;
        dst_dly_reg <= dst_lin_reg;
        sum_reg     <= sum_next;
        rhs_reg     <= rhs_next;
        root_reg    <= root_next;
        alpha_reg[0] <= alpha_next;
        for (int s = 0; s < STEPS; s++)
        begin
            alpha_reg[s+1] <= alpha_reg[s];
        end
    end

    assign blended_valid = sq_valid_reg[STEPS];
    assign blended_pixel = {alpha_reg[STEPS], root_reg[STEPS][2], root_reg[STEPS][1],
                            root_reg[STEPS][0]};

    `GABP_ASSERT_DELAY(a_result_follows_item, clk, rst_n, accept, 12, blended_valid)
    `GABP_ASSERT_IMPL(a_result_has_item, clk, rst_n, blended_valid, $past(accept, gabp_pkg::LATENCY))
    `GABP_ASSERT_IMPL(a_opacity_only_by_write, clk, rst_n, opacity_reg != $past(opacity_reg), $past(cfg_valid && cfg_ready))

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 250;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] source_pixel;
    logic [31:0] target_pixel;
    logic        blended_valid;
    logic [31:0] blended_pixel;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  blend_opacity;

    logic [31:0] expected_pixels[$];
    logic [8:0]  opacity_copy = gabp_pkg::OPACITY_ONE;
    int          blend_errors = 0;
    int          pixels_sent = 0;
    int          pixels_checked = 0;
    int          opacity_writes = 0;
    int          cycle_count = 0;
    bit          idling = 1'b1;

    gamma2_alpha_blend_pixel_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .source_pixel  (source_pixel),
        .target_pixel  (target_pixel),
        .blended_valid (blended_valid),
        .blended_pixel (blended_pixel),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .blend_opacity (blend_opacity)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic gabp_pkg::lin_t colour_to_lin(input logic [7:0] c);
        logic [63:0] num;
        num = 64'(c) * 64'(c) * 64'd131072 + 64'd65025;
        return gabp_pkg::lin_t'(num / 64'd130050);
    endfunction

    function automatic gabp_pkg::lin_t alpha_to_lin(input logic [7:0] a);
        logic [63:0] num;
        num = 64'(a) * 64'd131072 + 64'd255;
        return gabp_pkg::lin_t'(num / 64'd510);
    endfunction

    function automatic gabp_pkg::lin_t apply_opacity(input gabp_pkg::lin_t s,
                                                     input logic [8:0] op);
        logic [63:0] prod;
        prod = 64'(s) * 64'(op) + 64'd128;
        return gabp_pkg::lin_t'(prod >> 8);
    endfunction

    function automatic gabp_pkg::sum_t over_mix(input gabp_pkg::lin_t d,
                                                input gabp_pkg::lin_t s,
                                                input gabp_pkg::lin_t sa);
        logic [63:0] keep;
        keep = 64'(d) * (64'd65536 - 64'(sa)) + 64'd32768;
        return gabp_pkg::sum_t'(keep >> 16) + gabp_pkg::sum_t'(s);
    endfunction

    function automatic logic [7:0] lin_to_colour(input gabp_pkg::sum_t x);
        logic [63:0] rhs;
        logic [63:0] k;
        logic [7:0]  n;
        logic [7:0]  t;
        rhs = 64'd260100 * 64'(x);
        n = 8'd0;
        for (int b = 7; b >= 0; b--)
        begin
            t = n | (8'd1 << b);
            k = 64'd2 * 64'(t) - 64'd1;
            if (k * k * 64'd65536 <= rhs)
                n = t;
        end
        return n;
    endfunction

    function automatic logic [7:0] lin_to_alpha(input gabp_pkg::sum_t x);
        logic [63:0] v;
        v = (64'd510 * 64'(x) + 64'd65536) >> 17;
        return (v > 64'd255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [31:0] predict_blend(input logic [31:0] src, input logic [31:0] dst,
                                                  input logic [8:0] opacity);
        logic [8:0]     op;
        gabp_pkg::lin_t sa;
        gabp_pkg::lin_t da;
        gabp_pkg::lin_t s_lin;
        gabp_pkg::lin_t d_lin;
        logic [31:0]    pix;
        op = (opacity > gabp_pkg::OPACITY_ONE) ? gabp_pkg::OPACITY_ONE : opacity;
        sa = apply_opacity(alpha_to_lin(src[31:24]), op);
        da = alpha_to_lin(dst[31:24]);
        pix = 32'(lin_to_alpha(over_mix(da, sa, sa))) << 24;
        for (int sh = 0; sh <= 16; sh += 8)
        begin
            s_lin = apply_opacity(colour_to_lin(src[sh +: 8]), op);
            d_lin = colour_to_lin(dst[sh +: 8]);
            pix[sh +: 8] = lin_to_colour(over_mix(d_lin, s_lin, sa));
        end
        return pix;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (blend_errors < 100)
            $display("Mismatch at %0t: %s got %08h expected %08h", $time, what, got, want);
        blend_errors++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                opacity_copy = blend_opacity;
            if (blended_valid)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("unexpected blended_pixel", blended_pixel, 32'h0);
                else
                begin
                    if (blended_pixel !== expected_pixels[0])
                        report_mismatch("blended_pixel", blended_pixel, expected_pixels[0]);
                    void'(expected_pixels.pop_front());
                    pixels_checked++;
                end
            end
            if (start && !busy)
                expected_pixels.push_back(predict_blend(source_pixel, target_pixel,
                                                        opacity_copy));
        end
    end

    function automatic int pick_gap();
        int r;
        if (!idling)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        source_pixel = src;
        target_pixel = dst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_opacity(input logic [8:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        blend_opacity = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        blend_opacity = 9'($urandom_range(0, 511));
        opacity_writes++;
    endtask

    function automatic logic [31:0] random_premultiplied();
        logic [7:0] a;
        a = 8'($urandom_range(0, 255));
        return {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)),
                8'($urandom_range(0, a))};
    endfunction

    function automatic logic [31:0] random_extreme();
        case ($urandom_range(0, 3))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return {8'h00, 24'($urandom())};
            default: return {8'hff, 24'($urandom())};
        endcase
    endfunction

    task automatic test_default_opacity();
        send_pixel(32'h0000_0000, 32'h0000_0000);
        send_pixel(32'hffff_ffff, 32'h0000_0000);
        send_pixel(32'h0000_0000, 32'hffff_ffff);
        send_pixel(32'hff00_0000, 32'hffff_ffff);
        send_pixel(32'h00ff_ffff, 32'hffff_ffff);
        send_pixel(32'h80ff_4020, 32'h8040_c0ff);
        send_pixel(32'h0101_0101, 32'hfefe_fefe);
        send_pixel(32'h8080_8080, 32'h7f7f_7f7f);
    endtask

    task automatic test_opacity_extremes();
        logic [8:0] settings[5];
        settings = '{9'd0, 9'd511, 9'd257, 9'd1, 9'd255};
        foreach (settings[i])
        begin
            write_opacity(settings[i]);
            send_pixel(32'hffff_ffff, 32'h0000_0000);
            send_pixel(32'h7f7f_7f7f, 32'hff80_4010);
            send_pixel(32'h20ff_ffff, 32'hffff_ffff);
        end
    endtask

    task automatic test_random_blend();
        logic [31:0] src;
        logic [31:0] dst;
        int          r;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_opacity(gabp_pkg::OPACITY_ONE);
                1: write_opacity(9'($urandom_range(0, 511)));
                2: write_opacity(9'($urandom_range(1, 255)));
                3: write_opacity(gabp_pkg::OPACITY_ONE);
                4: write_opacity(9'($urandom_range(257, 511)));
                default: write_opacity(9'($urandom_range(0, 256)));
            endcase
            idling = (phase != 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    src = random_premultiplied();
                else if (r < 85)
                    src = $urandom();
                else
                    src = random_extreme();
                r = $urandom_range(0, 99);
                if (r < 80)
                    dst = $urandom();
                else
                    dst = random_extreme();
                send_pixel(src, dst);
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
            end
        end
        idling = 1'b1;
    endtask

    initial
    begin
        int spare;
        rst_n = 1'b0;
        start = 1'b0;
        source_pixel = 32'h0;
        target_pixel = 32'h0;
        cfg_valid = 1'b0;
        blend_opacity = gabp_pkg::OPACITY_ONE;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_opacity();
        test_opacity_extremes();
        test_random_blend();

        start = 1'b0;
        spare = 0;
        while (expected_pixels.size() != 0 && spare < 1000)
        begin
            @(negedge clk);
            spare++;
        end
        repeat (gabp_pkg::LATENCY + 4) @(negedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch("missing results", 32'(expected_pixels.size()), 32'h0);

        $display("Blended %0d pixels, %0d checked, across %0d opacity writes.",
                 pixels_sent, pixels_checked, opacity_writes);
        $display("Covered zero, saturating and partial opacity, and colour above alpha.");
        if (blend_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
